// ----- rtl/rds_pkg.sv -----
// shared constants, register codes and configuration type of the dispersion score block
`timescale 1ns / 1ps
`default_nettype none
package rds_pkg;

	localparam int IN_LANES        = 4;
	localparam int MAX_REP_DEF     = 4;
	localparam int COUNT_BITS_DEF  = 24;

	localparam int RCNT_W   = 3;
	localparam int LIB_W    = 32;
	localparam int GRAND_W  = 34;
	localparam int CUT_W    = 32;
	localparam int SCORE_W  = 32;
	localparam int FRAC_W   = 32;

	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int IDX_LSB  = 3;

	localparam int TERM_W   = 71;
	localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (TERM_W - 1);
	localparam int ACC_W    = TERM_W + $clog2(IN_LANES);

	localparam int QUO_W    = 64;
	localparam int DIV_STEP = 8;
	localparam int DIV_STG  = QUO_W / DIV_STEP;
	localparam int ROOT_W   = QUO_W / 2;

	localparam int TOP_LAT  = 2;
	localparam int LANE_LAT = TERM_W + 6;
	localparam int FIN_LAT  = 3 + DIV_STG + ROOT_W;
	localparam int TOTAL_LAT = TOP_LAT + LANE_LAT + FIN_LAT;

	localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(2);
	localparam logic [RCNT_W-1:0] RCNT_MIN   = RCNT_W'(2);

	typedef enum logic [2:0] {
		REG_RCNT   = 3'd0,
		REG_LIB0   = 3'd1,
		REG_LIB1   = 3'd2,
		REG_LIB2   = 3'd3,
		REG_LIB3   = 3'd4,
		REG_GRAND  = 3'd5,
		REG_CUTOFF = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [RCNT_W-1:0]               rcnt;
		logic [IN_LANES-1:0][LIB_W-1:0] lib;
		logic [GRAND_W-1:0]              grand;
		logic [CUT_W-1:0]                cutoff;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/replicate_dispersion_score.sv -----
// top level of the replicate dispersion score pipeline
//
//  port group      | direction | transfer
//  ----------------+-----------+--------------------------------------------
//  apb config      | in / out  | psel & penable & pwrite, 64-bit word, 8*i
//  start, reads_*  | in        | word taken when start high and busy low
//  done, score ... | out       | one word per cycle, marked by done
//
// one profile enters per cycle; busy never rises
// latency from start to done comes mostly from the 71-stage
// per-lane long division and the 32-stage square root
// arst_n clears all valid bits and loads the register reset values
// results cannot be held off; the pipeline never stalls
`timescale 1ns / 1ps
`default_nettype none
module replicate_dispersion_score #(
	parameter int MAX_REPLICATES = rds_pkg::MAX_REP_DEF,
	parameter int COUNT_BITS     = rds_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rds_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rds_pkg::DATA_W-1:0]    pwdata,
	output logic      [rds_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [COUNT_BITS-1:0]         reads_0,
	input  wire logic [COUNT_BITS-1:0]         reads_1,
	input  wire logic [COUNT_BITS-1:0]         reads_2,
	input  wire logic [COUNT_BITS-1:0]         reads_3,
	output logic                               done,
	output logic      [rds_pkg::SCORE_W-1:0]   score,
	output logic                               exceeds_cutoff,
	output logic                               zero_estimate
);

	localparam int LN    = rds_pkg::IN_LANES;
	localparam int SUM_W = COUNT_BITS + $clog2(LN);
	localparam int RLIM  = (MAX_REPLICATES < LN) ? MAX_REPLICATES : LN;

	rds_pkg::cfg_t                         cfg;
	logic [rds_pkg::RCNT_W-1:0]            n_eff;
	logic [rds_pkg::RCNT_W-1:0]            nm1;
	logic [LN-1:0][COUNT_BITS-1:0]         reads;
	logic [LN-1:0]                         act;
	logic [LN-1:0][COUNT_BITS-1:0]         y_s1;
	logic [LN-1:0]                         act_s1;
	logic                                  vld_s1;
	logic [LN-1:0][COUNT_BITS-1:0]         y_s2;
	logic [LN-1:0]                         act_s2;
	logic [SUM_W-1:0]                      sum_s2;
	logic                                  vld_s2;
	logic [SUM_W-1:0]                      sum;
	logic [LN-1:0]                         lane_vld;
	logic [LN-1:0][rds_pkg::TERM_W-1:0]    term;
	logic [LN-1:0]                         zf;

	rds_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy  = 1'b0;
	assign reads = {reads_3, reads_2, reads_1, reads_0};

	always_comb begin
		n_eff = cfg.rcnt;
		if (n_eff < rds_pkg::RCNT_MIN) begin
			n_eff = rds_pkg::RCNT_MIN;
		end
		if (n_eff > rds_pkg::RCNT_W'(RLIM)) begin
			n_eff = rds_pkg::RCNT_W'(RLIM);
		end
		nm1 = n_eff - rds_pkg::RCNT_W'(1);
	end

	for (genvar i = 0; i < LN; i++) begin : g_act
		assign act[i] = rds_pkg::RCNT_W'(i) < n_eff;
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < LN; i++) begin
			sum = sum + SUM_W'(y_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LN; i++) begin
			y_s1[i] <= act[i] ? reads[i] : '0;
		end
		act_s1 <= act;
		y_s2   <= y_s1;
		act_s2 <= act_s1;
		sum_s2 <= sum;
	end

	for (genvar i = 0; i < LN; i++) begin : g_lane
		rds_term #(
			.COUNT_BITS (COUNT_BITS),
			.SUM_W      (SUM_W)
		) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_i   (vld_s2),
			.y_i     (y_s2[i]),
			.s_i     (sum_s2),
			.act_i   (act_s2[i]),
			.lib_i   (cfg.lib[i]),
			.grand_i (cfg.grand),
			.vld_o   (lane_vld[i]),
			.term_o  (term[i]),
			.zf_o    (zf[i])
		);
	end

	rds_fin u_fin (
		.clk            (clk),
		.arst_n         (arst_n),
		.vld_i          (&lane_vld),
		.term_i         (term),
		.zf_i           (zf),
		.nm1_i          (nm1),
		.cutoff_i       (cfg.cutoff),
		.done           (done),
		.score          (score),
		.exceeds_cutoff (exceeds_cutoff),
		.zero_estimate  (zero_estimate)
	);

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_vld == '0) || (lane_vld == '1))
		else $error("lane valid bits out of step");

	a_zero_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_estimate |-> score == '1)
		else $error("zero estimate without saturated score");

	a_cutoff_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> exceeds_cutoff == (score > cfg.cutoff))
		else $error("cutoff flag disagrees with score");

endmodule
`default_nettype wire

// ----- rtl/rds_cfg.sv -----
// configuration register file behind the apb port
`timescale 1ns / 1ps
`default_nettype none
module rds_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rds_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [rds_pkg::DATA_W-1:0]   pwdata,
	output logic      [rds_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output rds_pkg::cfg_t                     cfg
);

	rds_pkg::cfg_t     cfg_q;
	rds_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = rds_pkg::reg_idx_t'(paddr[rds_pkg::ADDR_W-1:rds_pkg::IDX_LSB]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rcnt   <= rds_pkg::RCNT_RESET;
			cfg_q.lib    <= '0;
			cfg_q.grand  <= '0;
			cfg_q.cutoff <= '1;
		end else if (wr) begin
			case (idx)
				rds_pkg::REG_RCNT:   cfg_q.rcnt   <= pwdata[rds_pkg::RCNT_W-1:0];
				rds_pkg::REG_LIB0:   cfg_q.lib[0] <= pwdata[rds_pkg::LIB_W-1:0];
				rds_pkg::REG_LIB1:   cfg_q.lib[1] <= pwdata[rds_pkg::LIB_W-1:0];
				rds_pkg::REG_LIB2:   cfg_q.lib[2] <= pwdata[rds_pkg::LIB_W-1:0];
				rds_pkg::REG_LIB3:   cfg_q.lib[3] <= pwdata[rds_pkg::LIB_W-1:0];
				rds_pkg::REG_GRAND:  cfg_q.grand  <= pwdata[rds_pkg::GRAND_W-1:0];
				rds_pkg::REG_CUTOFF: cfg_q.cutoff <= pwdata[rds_pkg::CUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rds_pkg::REG_RCNT:   prdata = rds_pkg::DATA_W'(cfg_q.rcnt);
			rds_pkg::REG_LIB0:   prdata = rds_pkg::DATA_W'(cfg_q.lib[0]);
			rds_pkg::REG_LIB1:   prdata = rds_pkg::DATA_W'(cfg_q.lib[1]);
			rds_pkg::REG_LIB2:   prdata = rds_pkg::DATA_W'(cfg_q.lib[2]);
			rds_pkg::REG_LIB3:   prdata = rds_pkg::DATA_W'(cfg_q.lib[3]);
			rds_pkg::REG_GRAND:  prdata = rds_pkg::DATA_W'(cfg_q.grand);
			rds_pkg::REG_CUTOFF: prdata = rds_pkg::DATA_W'(cfg_q.cutoff);
			default:             prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/rds_term.sv -----
// one replicate lane: products, squared deviation and pipelined long division
`timescale 1ns / 1ps
`default_nettype none
module rds_term #(
	parameter int COUNT_BITS = rds_pkg::COUNT_BITS_DEF,
	parameter int SUM_W      = COUNT_BITS + 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vld_i,
	input  wire logic [COUNT_BITS-1:0]         y_i,
	input  wire logic [SUM_W-1:0]              s_i,
	input  wire logic                          act_i,
	input  wire logic [rds_pkg::LIB_W-1:0]     lib_i,
	input  wire logic [rds_pkg::GRAND_W-1:0]   grand_i,
	output logic                               vld_o,
	output logic      [rds_pkg::TERM_W-1:0]    term_o,
	output logic                               zf_o
);

	localparam int TW     = rds_pkg::TERM_W;
	localparam int YG_W   = COUNT_BITS + rds_pkg::GRAND_W;
	localparam int SL_W   = SUM_W + rds_pkg::LIB_W;
	localparam int D_W    = (YG_W > SL_W) ? YG_W : SL_W;
	localparam int H_W    = (D_W + 1) / 2;
	localparam int DH_W   = D_W - H_W;
	localparam int SLL_W  = (SL_W + 1) / 2;
	localparam int SLH_W  = SL_W - SLL_W;
	localparam int SQ_W   = 2 * D_W;
	localparam int NUM_W  = SQ_W + rds_pkg::FRAC_W;
	localparam int DEN_W  = rds_pkg::GRAND_W + SL_W;
	localparam int GH_W   = rds_pkg::GRAND_W + SLH_W;
	localparam int GL_W   = rds_pkg::GRAND_W + SLL_W;

	logic [YG_W-1:0]          yg_s1;
	logic [SL_W-1:0]          sl_s1;
	logic [D_W-1:0]           d_s2;
	logic [SL_W-1:0]          sl_s2;
	logic [2*DH_W-1:0]        hh_s3;
	logic [DH_W+H_W-1:0]      hl_s3;
	logic [2*H_W-1:0]         ll_s3;
	logic [GH_W-1:0]          gh_s3;
	logic [GL_W-1:0]          gl_s3;
	logic [SQ_W-1:0]          sq_s4;
	logic [DEN_W-1:0]         den_s4;
	logic [NUM_W-1:0]         num;
	logic [3:0]               vld_p;
	logic [3:0]               zf_p;
	logic [3:0]               live_p;

	logic [TW:0][DEN_W-1:0]   rem_s;
	logic [TW:0][TW-1:0]      qx_s;
	logic [TW:0][DEN_W-1:0]   den_s;
	logic [TW:0]              vld_s;
	logic [TW:0]              sat_s;
	logic [TW:0]              live_s;
	logic [TW:0]              zf_s;
	logic [TW-1:0]            tq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= '0;
		end else begin
			vld_p <= {vld_p[2:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		yg_s1     <= YG_W'(y_i) * YG_W'(grand_i);
		sl_s1     <= SL_W'(s_i) * SL_W'(lib_i);
		zf_p[0]   <= act_i & (y_i != '0) & ((grand_i == '0) | (lib_i == '0));
		live_p[0] <= act_i & (s_i != '0) & (grand_i != '0) & (lib_i != '0);

		d_s2      <= (D_W'(yg_s1) >= D_W'(sl_s1)) ? D_W'(yg_s1) - D_W'(sl_s1)
		                                          : D_W'(sl_s1) - D_W'(yg_s1);
		sl_s2     <= sl_s1;

		hh_s3     <= (2*DH_W)'(d_s2[D_W-1:H_W]) * (2*DH_W)'(d_s2[D_W-1:H_W]);
		hl_s3     <= (DH_W+H_W)'(d_s2[D_W-1:H_W]) * (DH_W+H_W)'(d_s2[H_W-1:0]);
		ll_s3     <= (2*H_W)'(d_s2[H_W-1:0]) * (2*H_W)'(d_s2[H_W-1:0]);
		gh_s3     <= GH_W'(grand_i) * GH_W'(sl_s2[SL_W-1:SLL_W]);
		gl_s3     <= GL_W'(grand_i) * GL_W'(sl_s2[SLL_W-1:0]);

		sq_s4     <= (SQ_W'(hh_s3) << (2*H_W)) + (SQ_W'(hl_s3) << (H_W+1)) + SQ_W'(ll_s3);
		den_s4    <= (DEN_W'(gh_s3) << SLL_W) + DEN_W'(gl_s3);

		zf_p[3:1]   <= zf_p[2:0];
		live_p[3:1] <= live_p[2:0];
	end

	assign num = {sq_s4, rds_pkg::FRAC_W'(0)};

	// division entry: quotient above its width means saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_p[3];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= DEN_W'(num[NUM_W-1:TW]);
		qx_s[0]   <= num[TW-1:0];
		den_s[0]  <= den_s4;
		sat_s[0]  <= (num[NUM_W-1:TW] >= den_s4);
		live_s[0] <= live_p[3];
		zf_s[0]   <= zf_p[3];
	end

	for (genvar k = 0; k < TW; k++) begin : g_div
		logic [DEN_W:0] rs;
		logic           ge;
		logic [DEN_W:0] diff;

		assign rs   = {rem_s[k], qx_s[k][TW-1]};
		assign ge   = rs >= {1'b0, den_s[k]};
		assign diff = rs - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
			qx_s[k+1]   <= {qx_s[k][TW-2:0], ge};
			den_s[k+1]  <= den_s[k];
			sat_s[k+1]  <= sat_s[k];
			live_s[k+1] <= live_s[k];
			zf_s[k+1]   <= zf_s[k];
		end
	end

	assign tq = (sat_s[TW] || (qx_s[TW] > rds_pkg::TERM_CAP)) ? rds_pkg::TERM_CAP : qx_s[TW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_s[TW];
		end
	end

	always_ff @(posedge clk) begin
		term_o <= live_s[TW] ? tq : '0;
		zf_o   <= zf_s[TW];
	end

endmodule
`default_nettype wire

// ----- rtl/rds_fin.sv -----
// lane sum, division by replicates minus one, square root and cutoff compare
`timescale 1ns / 1ps
`default_nettype none
module rds_fin (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              vld_i,
	input  wire logic [rds_pkg::IN_LANES-1:0][rds_pkg::TERM_W-1:0] term_i,
	input  wire logic [rds_pkg::IN_LANES-1:0]                      zf_i,
	input  wire logic [rds_pkg::RCNT_W-1:0]                        nm1_i,
	input  wire logic [rds_pkg::CUT_W-1:0]                         cutoff_i,
	output logic                                                   done,
	output logic      [rds_pkg::SCORE_W-1:0]                       score,
	output logic                                                   exceeds_cutoff,
	output logic                                                   zero_estimate
);

	localparam int AW  = rds_pkg::ACC_W;
	localparam int QW  = rds_pkg::QUO_W;
	localparam int NW  = rds_pkg::RCNT_W;
	localparam int DS  = rds_pkg::DIV_STG;
	localparam int STP = rds_pkg::DIV_STEP;
	localparam int RW  = rds_pkg::ROOT_W;
	localparam int MW  = RW + 2;

	logic [AW-1:0]        acc;
	logic [AW-1:0]        acc_s1;
	logic                 zero_s1;
	logic                 vld_s1;

	logic [DS:0][NW-1:0]  dr_s;
	logic [DS:0][QW-1:0]  dq_s;
	logic [DS:0]          dvld_s;
	logic [DS:0]          dsat_s;
	logic [DS:0]          dzero_s;

	logic [RW:0][MW-1:0]  rm_s;
	logic [RW:0][RW-1:0]  rt_s;
	logic [RW:0][QW-1:0]  rv_s;
	logic [RW:0]          rvld_s;
	logic [RW:0]          rsat_s;
	logic [RW:0]          rzero_s;

	logic [rds_pkg::SCORE_W-1:0] fin_score;

	always_comb begin
		acc = '0;
		for (int i = 0; i < rds_pkg::IN_LANES; i++) begin
			acc = acc + AW'(term_i[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			dvld_s[0] <= 1'b0;
		end else begin
			vld_s1    <= vld_i;
			dvld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		acc_s1     <= acc;
		zero_s1    <= |zf_i;
		dr_s[0]    <= NW'(acc_s1[AW-1:QW]);
		dq_s[0]    <= acc_s1[QW-1:0];
		dsat_s[0]  <= zero_s1 | (acc_s1 >= (AW'(nm1_i) << QW));
		dzero_s[0] <= zero_s1;
	end

	for (genvar j = 0; j < DS; j++) begin : g_div
		logic [NW-1:0] r;
		logic [QW-1:0] q;
		logic [NW:0]   rs;

		always_comb begin
			r  = dr_s[j];
			q  = dq_s[j];
			rs = '0;
			for (int b = 0; b < STP; b++) begin
				rs = {r, q[QW-1]};
				if (rs >= {1'b0, nm1_i}) begin
					rs = rs - {1'b0, nm1_i};
					q  = {q[QW-2:0], 1'b1};
				end else begin
					q  = {q[QW-2:0], 1'b0};
				end
				r = rs[NW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[j+1] <= 1'b0;
			end else begin
				dvld_s[j+1] <= dvld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dr_s[j+1]    <= r;
			dq_s[j+1]    <= q;
			dsat_s[j+1]  <= dsat_s[j];
			dzero_s[j+1] <= dzero_s[j];
		end
	end

	assign rm_s[0]    = '0;
	assign rt_s[0]    = '0;
	assign rv_s[0]    = dq_s[DS];
	assign rvld_s[0]  = dvld_s[DS];
	assign rsat_s[0]  = dsat_s[DS];
	assign rzero_s[0] = dzero_s[DS];

	// digit-by-digit square root, one root bit per stage
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [MW+1:0] tmp;
		logic [MW+1:0] trial;
		logic          ge;
		logic [MW+1:0] diff;

		assign tmp   = {rm_s[k], rv_s[k][QW-1:QW-2]};
		assign trial = (MW+2)'({rt_s[k], 2'b01});
		assign ge    = tmp >= trial;
		assign diff  = tmp - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rvld_s[k+1] <= 1'b0;
			end else begin
				rvld_s[k+1] <= rvld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rm_s[k+1]    <= ge ? diff[MW-1:0] : tmp[MW-1:0];
			rt_s[k+1]    <= {rt_s[k][RW-2:0], ge};
			rv_s[k+1]    <= {rv_s[k][QW-3:0], 2'b00};
			rsat_s[k+1]  <= rsat_s[k];
			rzero_s[k+1] <= rzero_s[k];
		end
	end

	assign fin_score = rsat_s[RW] ? '1 : rt_s[RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rvld_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		score          <= fin_score;
		exceeds_cutoff <= fin_score > cutoff_i;
		zero_estimate  <= rzero_s[RW];
	end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the replicate dispersion score block
`timescale 1ns / 1ps
module tb_top;
	import rds_pkg::*;

	localparam int CNT_W = COUNT_BITS_DEF;
	localparam int DRAIN = TOTAL_LAT + 10;
	localparam int WATCHDOG = 4000;

	typedef struct {
		logic [31:0] score;
		logic        exceeds;
		logic        zero_est;
	} score_word_t;

	class score_board;
		logic [RCNT_W-1:0] rcnt = RCNT_RESET;
		logic [LIB_W-1:0]  lib [IN_LANES];
		logic [GRAND_W-1:0] grand = '0;
		logic [CUT_W-1:0]  cutoff = '1;
		score_word_t       pending_q [$];
		int                errors = 0;
		int                checked = 0;
		int                saturated = 0;
		int                flagged = 0;

		function new();
			foreach (lib[i]) lib[i] = '0;
		endfunction

		function automatic logic [31:0] root64(logic [63:0] v);
			logic [31:0]  r;
			logic [31:0]  c;
			logic [127:0] sq;
			r = '0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (32'd1 << b);
				sq = 128'(c) * 128'(c);
				if (sq <= 128'(v)) r = c;
			end
			return r;
		endfunction

		function automatic score_word_t dispersion(logic [3:0][CNT_W-1:0] y);
			score_word_t w;
			int           n;
			logic [255:0] s, yg, sl, d, num, den, t, acc, q;
			logic         zero;
			n = (rcnt < 2) ? 2 : (rcnt > 4) ? 4 : int'(rcnt);
			s = '0;
			acc = '0;
			zero = 1'b0;
			for (int i = 0; i < n; i++) s += 256'(y[i]);
			if (s == 0) begin
				w.score = '0;
			end else begin
				for (int i = 0; i < n; i++) begin
					if (grand == 0 || lib[i] == 0) begin
						if (y[i] != 0) zero = 1'b1;
						continue;
					end
					yg = 256'(y[i]) * 256'(grand);
					sl = s * 256'(lib[i]);
					d = (yg >= sl) ? yg - sl : sl - yg;
					num = (d * d) << 32;
					den = 256'(grand) * sl;
					t = num / den;
					if (t > (256'd1 << 70)) t = 256'd1 << 70;
					acc += t;
				end
				if (zero) begin
					w.score = '1;
				end else begin
					q = acc / 256'(n - 1);
					if (q[255:64] != 0) w.score = '1;
					else w.score = root64(q[63:0]);
				end
			end
			w.zero_est = zero;
			w.exceeds = w.score > cutoff;
			return w;
		endfunction

		function void note(logic [3:0][CNT_W-1:0] y);
			pending_q.push_back(dispersion(y));
		endfunction

		function void check(logic [31:0] sc, logic ex, logic ze);
			score_word_t e;
			checked++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word score=%h exceeds=%b zero=%b", $time, sc, ex, ze);
				return;
			end
			e = pending_q.pop_front();
			if (sc == '1) saturated++;
			if (ex) flagged++;
			if (sc !== e.score) begin
				errors++;
				$display("%0t: score expected %h actual %h", $time, e.score, sc);
			end
			if (ex !== e.exceeds) begin
				errors++;
				$display("%0t: exceeds_cutoff expected %b actual %b", $time, e.exceeds, ex);
			end
			if (ze !== e.zero_est) begin
				errors++;
				$display("%0t: zero_estimate expected %b actual %b", $time, e.zero_est, ze);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [CNT_W-1:0] reads_0 = '0, reads_1 = '0, reads_2 = '0, reads_3 = '0;
	logic done;
	logic [SCORE_W-1:0] score;
	logic exceeds_cutoff, zero_estimate;

	score_board sb = new();
	int accepted = 0;
	int idle_cycles = 0;
	logic no_idle = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	replicate_dispersion_score DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.reads_0(reads_0), .reads_1(reads_1), .reads_2(reads_2), .reads_3(reads_3),
		.done(done), .score(score), .exceeds_cutoff(exceeds_cutoff),
		.zero_estimate(zero_estimate)
	);

	always @(posedge clk) begin
		if (done) sb.check(score, exceeds_cutoff, zero_estimate);
	end

	always @(posedge clk) begin
		if (done || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("timeout with %0d words outstanding", sb.pending_q.size());
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(idx) << IDX_LSB;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RCNT:   sb.rcnt = val[RCNT_W-1:0];
			REG_LIB0:   sb.lib[0] = val[LIB_W-1:0];
			REG_LIB1:   sb.lib[1] = val[LIB_W-1:0];
			REG_LIB2:   sb.lib[2] = val[LIB_W-1:0];
			REG_LIB3:   sb.lib[3] = val[LIB_W-1:0];
			REG_GRAND:  sb.grand = val[GRAND_W-1:0];
			REG_CUTOFF: sb.cutoff = val[CUT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(int rc, logic [3:0][31:0] libs, logic [33:0] g,
			logic [31:0] cut);
		reg_write(REG_RCNT, 64'(rc));
		reg_write(REG_LIB0, 64'(libs[0]));
		reg_write(REG_LIB1, 64'(libs[1]));
		reg_write(REG_LIB2, 64'(libs[2]));
		reg_write(REG_LIB3, 64'(libs[3]));
		reg_write(REG_GRAND, 64'(g));
		reg_write(REG_CUTOFF, 64'(cut));
	endtask

	task automatic send_profile(logic [3:0][CNT_W-1:0] y);
		int gap;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		reads_0 <= y[0];
		reads_1 <= y[1];
		reads_2 <= y[2];
		reads_3 <= y[3];
		do @(posedge clk); while (busy);
		sb.note(y);
		accepted++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [CNT_W-1:0] rand_count();
		int k;
		k = $urandom_range(1, CNT_W);
		return CNT_W'($urandom) & CNT_W'((64'd1 << k) - 1);
	endfunction

	function automatic logic [3:0][CNT_W-1:0] rand_profile();
		logic [3:0][CNT_W-1:0] y;
		logic [63:0] s, e;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) y[i] = rand_count();
		case (mode)
			0: y = '0;
			1: for (int i = 0; i < 4; i++) y[i] = CNT_W'($urandom);
			2: begin
				y = '0;
				y[$urandom_range(0, 3)] = '1;
			end
			3, 4, 5: if (sb.grand != 0) begin
				s = 64'(rand_count()) * 3;
				for (int i = 0; i < 4; i++) begin
					e = s * 64'(sb.lib[i]) / 64'(sb.grand);
					e = e + $urandom_range(0, 3);
					y[i] = (e > 64'hFFFFFF) ? '1 : CNT_W'(e);
				end
			end
			default: ;
		endcase
		return y;
	endfunction

	task automatic random_phase(int rc, logic [31:0] cut, int count, logic lib_max);
		logic [3:0][31:0] libs;
		logic [33:0] g;
		int n;
		n = (rc < 2) ? 2 : (rc > 4) ? 4 : rc;
		g = '0;
		for (int i = 0; i < 4; i++) begin
			libs[i] = lib_max ? 32'hFFFF_FFFF : ($urandom >> $urandom_range(0, 31)) | 32'd1;
			if (i < n) g += 34'(libs[i]);
		end
		load_config(rc, libs, g, cut);
		repeat (count) send_profile(rand_profile());
		drain();
	endtask

	initial begin
		logic [3:0][CNT_W-1:0] y;
		logic [3:0][31:0] libs;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: typical totals, edge counts
		libs = {32'd4000000, 32'd3000000, 32'd2000000, 32'd1000000};
		load_config(4, libs, 34'd10000000, 32'h0001_0000);
		send_profile('0);
		send_profile({4{24'hFFFFFF}});
		send_profile({24'd4, 24'd3, 24'd2, 24'd1});
		send_profile({24'd400, 24'd300, 24'd200, 24'd100});
		send_profile({24'd0, 24'd0, 24'd0, 24'hFFFFFF});
		send_profile({24'hFFFFFF, 24'd0, 24'd0, 24'd0});
		send_profile({24'h000001, 24'h0, 24'h0, 24'h0});
		send_profile({24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555});
		send_profile({24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});
		drain();
		// zero totals: zero estimate and lanes that add nothing
		libs = {32'd7, 32'd0, 32'd5, 32'd0};
		load_config(4, libs, 34'd12, 32'd0);
		send_profile({24'd1, 24'd0, 24'd1, 24'd0});
		send_profile({24'd1, 24'd1, 24'd1, 24'd0});
		send_profile({24'd0, 24'd0, 24'd0, 24'd0});
		send_profile({24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0});
		drain();
		load_config(2, libs, 34'd0, 32'hFFFF_FFFF);
		send_profile({24'd9, 24'd9, 24'd0, 24'd0});
		send_profile({24'd9, 24'd9, 24'd0, 24'd1});
		send_profile('0);
		drain();

		random_phase(2, $urandom, 110, 1'b0);
		random_phase(3, $urandom, 110, 1'b0);
		random_phase(4, 32'd0, 110, 1'b1);
		random_phase(0, 32'hFFFF_FFFF, 100, 1'b0);
		random_phase(1, $urandom >> 8, 100, 1'b0);
		random_phase(7, $urandom >> 12, 100, 1'b0);
		random_phase(5, 32'h0002_0000, 100, 1'b0);
		libs = {32'hFFFF_FFFF, 32'd1, 32'd0, 32'd3};
		load_config(4, libs, 34'h3_FFFF_FFFF, $urandom);
		repeat (60) send_profile(rand_profile());
		drain();
		no_idle = 1'b1;
		random_phase(4, $urandom >> 4, 120, 1'b0);

		start <= 1'b0;
		repeat (DRAIN) @(posedge clk);
		$display("%0d profiles sent over twelve register settings, %0d scores checked",
			accepted, sb.checked);
		$display("%0d saturated scores, %0d flagged over cutoff", sb.saturated, sb.flagged);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
